// ----- rtl/core/scc_pkg.sv -----
package scc_pkg;

  localparam int NUM_SLOTS_DEF = 64;
  localparam int SLOT_W = 6;
  localparam int SECTOR_W = 32;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [SECTOR_W-1:0] sector;
  } cmd_t;

  // Handshake between the front queue and the back engine.
  typedef struct packed {
    logic avail;
    cmd_t cmd;
  } cmd_if_t;

endpackage

// ----- rtl/core/scc_front.sv -----
module scc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_req_type,
  input  logic [scc_pkg::SECTOR_W-1:0] in_sector,
  output scc_pkg::cmd_if_t             cmd_o,
  input  logic                         cmd_pop
);

  scc_pkg::cmd_t q_r [2];
  logic [1:0]    cnt_r, cnt_nxt;
  logic          rd_r, wr_r;
  logic          acc, enq, deq;
  scc_pkg::cmd_t cmd_in;
  logic          keep;

  assign full = (cnt_r == 2'd2);
  assign acc  = push && !full;

  always_comb begin
    keep          = 1'b1;
    cmd_in.sector = in_sector;
    unique case (in_req_type)
      scc_pkg::REQ_READ:  cmd_in.op = scc_pkg::OP_READ;
      scc_pkg::REQ_WRITE: cmd_in.op = scc_pkg::OP_WRITE;
      scc_pkg::REQ_FLUSH: cmd_in.op = scc_pkg::OP_FLUSH;
      default: begin
        // An unused request code is dropped here and never reaches the engine.
        cmd_in.op = scc_pkg::OP_READ;
        keep      = 1'b0;
      end
    endcase
  end

  assign enq = acc && keep;
  assign deq = cmd_pop && (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (enq) wr_r <= ~wr_r;
      if (deq) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) q_r[wr_r] <= cmd_in;
  end

  assign cmd_o.avail = (cnt_r != 2'd0);
  assign cmd_o.cmd   = q_r[rd_r];

endmodule

// ----- rtl/core/scc_back.sv -----
module scc_back #(
  parameter int NUM_SLOTS = scc_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  scc_pkg::cmd_if_t             cmd_i,
  output logic                         cmd_pop,
  output logic                         empty,
  input  logic                         pop,
  output logic [scc_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_hit,
  output logic                         out_fill,
  output logic                         out_writeback,
  output logic [scc_pkg::SECTOR_W-1:0] out_writeback_sector,
  output logic                         out_last
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  typedef struct packed {
    logic [scc_pkg::SLOT_W-1:0]   slot;
    logic                         hit;
    logic                         fill;
    logic                         wb;
    logic [scc_pkg::SECTOR_W-1:0] wb_sector;
    logic                         last;
  } res_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_SWEEP = 6'b000100,
    S_VICT  = 6'b001000,
    S_FLUSH = 6'b010000,
    S_FLRD  = 6'b100000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [NUM_SLOTS-1:0]         valid_r, dirty_r, acc_r, match_r;
  logic [scc_pkg::SECTOR_W-1:0] tag_r [NUM_SLOTS];
  logic [scc_pkg::SECTOR_W-1:0] tag_mem [NUM_SLOTS];
  logic [scc_pkg::SECTOR_W-1:0] rd_q;
  logic [scc_pkg::SECTOR_W-1:0] sector_r;
  logic                         wr_op_r;
  logic [IW-1:0]                hand_r, ptr_r, ptr_inc, hit_idx;
  logic                         hit_any;
  logic [NUM_SLOTS-1:0]         later_mask;
  logic                         more_dirty;

  // Two-entry result queue.
  res_t       oq_r [2];
  logic [1:0] ocnt_r;
  logic       ord_r, owr_r;
  logic       ofull, opush, odeq;
  res_t       res;

  assign ofull = (ocnt_r == 2'd2);
  assign odeq  = pop && (ocnt_r != 2'd0);
  assign ptr_inc = (ptr_r == LAST_IDX) ? '0 : ptr_r + IW'(1);

  always_comb begin
    hit_any = 1'b0;
    hit_idx = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        hit_any = 1'b1;
        hit_idx = IW'(i);
      end
    end
  end

  always_comb begin
    for (int j = 0; j < NUM_SLOTS; j++) begin
      later_mask[j] = (IW'(j) > ptr_r);
    end
  end
  assign more_dirty = |(valid_r & dirty_r & later_mask);

  always_comb begin
    state_nxt = state_r;
    cmd_pop   = 1'b0;
    opush     = 1'b0;
    res       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_i.avail) begin
          cmd_pop = 1'b1;
          if (cmd_i.cmd.op == scc_pkg::OP_FLUSH) state_nxt = S_FLUSH;
          else                                   state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        if (hit_any) begin
          res.slot = scc_pkg::SLOT_W'(hit_idx);
          res.hit  = 1'b1;
          res.last = 1'b1;
          if (!ofull) begin
            opush     = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      S_SWEEP: begin
        if (!(valid_r[ptr_r] && acc_r[ptr_r])) state_nxt = S_VICT;
      end
      S_VICT: begin
        res.slot      = scc_pkg::SLOT_W'(ptr_r);
        res.fill      = 1'b1;
        res.wb        = valid_r[ptr_r] && dirty_r[ptr_r];
        res.wb_sector = res.wb ? rd_q : '0;
        res.last      = 1'b1;
        if (!ofull) begin
          opush     = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_FLUSH: begin
        if (valid_r[ptr_r] && dirty_r[ptr_r]) state_nxt = S_FLRD;
        else if (ptr_r == LAST_IDX)           state_nxt = S_IDLE;
      end
      S_FLRD: begin
        res.slot      = scc_pkg::SLOT_W'(ptr_r);
        res.wb        = 1'b1;
        res.wb_sector = rd_q;
        res.last      = !more_dirty;
        if (!ofull) begin
          opush     = 1'b1;
          state_nxt = (ptr_r == LAST_IDX) ? S_IDLE : S_FLUSH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      dirty_r <= '0;
      acc_r   <= '0;
      hand_r  <= '0;
      ptr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (cmd_i.avail) ptr_r <= (cmd_i.cmd.op == scc_pkg::OP_FLUSH) ? '0 : hand_r;
        end
        S_LOOK: begin
          if (hit_any && !ofull) begin
            acc_r[hit_idx] <= 1'b1;
            if (wr_op_r) dirty_r[hit_idx] <= 1'b1;
          end
        end
        S_SWEEP: begin
          if (valid_r[ptr_r] && acc_r[ptr_r]) begin
            // Second chance: clear the access bit and move on.
            acc_r[ptr_r] <= 1'b0;
            ptr_r        <= ptr_inc;
          end else begin
            hand_r <= ptr_inc;
          end
        end
        S_VICT: begin
          if (!ofull) begin
            valid_r[ptr_r] <= 1'b1;
            dirty_r[ptr_r] <= wr_op_r;
            acc_r[ptr_r]   <= 1'b1;
          end
        end
        S_FLUSH: begin
          if (!(valid_r[ptr_r] && dirty_r[ptr_r]) && ptr_r != LAST_IDX) ptr_r <= ptr_inc;
        end
        S_FLRD: begin
          if (!ofull) begin
            dirty_r[ptr_r] <= 1'b0;
            if (ptr_r != LAST_IDX) ptr_r <= ptr_inc;
          end
        end
        default: ;
      endcase
    end
  end

  // Tag flops feed the parallel compare; the memory copy serves the single
  // indexed read needed for writebacks.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && cmd_i.avail) begin
      sector_r <= cmd_i.cmd.sector;
      wr_op_r  <= (cmd_i.cmd.op == scc_pkg::OP_WRITE);
      for (int i = 0; i < NUM_SLOTS; i++) begin
        match_r[i] <= valid_r[i] && (tag_r[i] == cmd_i.cmd.sector);
      end
    end
    if (state_r == S_VICT && !ofull) begin
      tag_r[ptr_r]   <= sector_r;
      tag_mem[ptr_r] <= sector_r;
    end
    rd_q <= tag_mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ocnt_r <= 2'd0;
      ord_r  <= 1'b0;
      owr_r  <= 1'b0;
    end else begin
      if (opush && !odeq)      ocnt_r <= ocnt_r + 2'd1;
      else if (odeq && !opush) ocnt_r <= ocnt_r - 2'd1;
      if (opush) owr_r <= ~owr_r;
      if (odeq)  ord_r <= ~ord_r;
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[owr_r] <= res;
  end

  assign empty                = (ocnt_r == 2'd0);
  assign out_slot             = oq_r[ord_r].slot;
  assign out_hit              = oq_r[ord_r].hit;
  assign out_fill             = oq_r[ord_r].fill;
  assign out_writeback        = oq_r[ord_r].wb;
  assign out_writeback_sector = oq_r[ord_r].wb_sector;
  assign out_last             = oq_r[ord_r].last;

endmodule

// ----- rtl/core/sector_cache_clock_replacement.sv -----
// Tag and replacement controller of a fully associative sector cache with
// clock replacement. Requests enter a two-entry queue and results leave
// through another, so either side may stall on its own. A hit goes through
// the tag compare as the request leaves the queue, then the result encode.
// A miss goes from the compare to a sweep in which the clock hand inspects
// slots, clearing the access bit of each used one, and then to the victim.
// A flush walks every slot in turn and writes back each dirty one, waiting
// while the result queue is full. Tags have no reset; valid, dirty and access
// bits clear at once on reset, so no clearing pass is needed.
module sector_cache_clock_replacement #(
  parameter int NUM_SLOTS = scc_pkg::NUM_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [1:0]                   in_req_type,
  input  logic [scc_pkg::SECTOR_W-1:0] in_sector,
  output logic                         empty,
  input  logic                         pop,
  output logic [scc_pkg::SLOT_W-1:0]   out_slot,
  output logic                         out_hit,
  output logic                         out_fill,
  output logic                         out_writeback,
  output logic [scc_pkg::SECTOR_W-1:0] out_writeback_sector,
  output logic                         out_last
);

  scc_pkg::cmd_if_t cmd;
  logic             cmd_pop;

  scc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_sector   (in_sector),
    .cmd_o       (cmd),
    .cmd_pop     (cmd_pop)
  );

  scc_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd_i                (cmd),
    .cmd_pop              (cmd_pop),
    .empty                (empty),
    .pop                  (pop),
    .out_slot             (out_slot),
    .out_hit              (out_hit),
    .out_fill             (out_fill),
    .out_writeback        (out_writeback),
    .out_writeback_sector (out_writeback_sector),
    .out_last             (out_last)
  );

endmodule

// ----- rtl/core/scc_checker.sv -----
module scc_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         empty,
  input logic                         pop,
  input logic                         out_hit,
  input logic                         out_fill,
  input logic                         out_writeback,
  input logic [scc_pkg::SECTOR_W-1:0] out_writeback_sector,
  input logic                         out_last
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result waiting after reset");

  // A hit never needs a fill or a writeback.
  a_hit_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_hit) |-> (!out_fill && !out_writeback))
    else $error("hit with fill or writeback");

  // Only a flush gives several results, and each of those is a writeback.
  a_nonlast_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_last) |-> (out_writeback && !out_fill && !out_hit))
    else $error("non-final beat is not a flush writeback");

  // Without a writeback the reported sector is zero.
  a_wb_sector: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !out_writeback) |-> (out_writeback_sector == '0))
    else $error("writeback sector set without writeback");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("waiting result withdrawn");

endmodule

bind sector_cache_clock_replacement scc_checker u_scc_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .empty                (empty),
  .pop                  (pop),
  .out_hit              (out_hit),
  .out_fill             (out_fill),
  .out_writeback        (out_writeback),
  .out_writeback_sector (out_writeback_sector),
  .out_last             (out_last)
);
